// ----- rtl/core/bbc_pkg.sv -----
// Bracket balance checker: shared types and constants.
// Holds character codes, bracket kinds and the queue entry type.
// No dependencies.
package bbc_pkg;

    // Character codes of the six brackets
    localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
    localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
    localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
    localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;

    // Bracket kinds as held on the stack
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_ROUND  = 2'd0;
    localparam kind_t KIND_SQUARE = 2'd1;
    localparam kind_t KIND_CURLY  = 2'd2;
    localparam kind_t KIND_NONE   = 2'd3;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Classified operation handed from front to back
    typedef struct packed {
        logic  last;
        logic  is_open;
        logic  is_close;
        kind_t kind;
    } op_t;

endpackage

// ----- rtl/core/bbc_in_if.sv -----
// Bracket balance checker: input channel carrying one character per item.
// Depends on nothing.
interface bbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

// ----- rtl/core/bbc_out_if.sv -----
// Bracket balance checker: result channel carrying one verdict per item.
// Depends on nothing.
interface bbc_out_if;
    logic valid;
    logic ready;
    logic finished;
    logic balanced;

    modport source (output valid, output finished, output balanced, input ready);
    modport sink   (input valid, input finished, input balanced, output ready);
endinterface

// ----- rtl/core/bracket_balance_checker.sv -----
// Bracket balance checker: top level joining front, queue and stack back end.
// Depends on bbc_pkg, bbc_in_if, bbc_out_if, bbc_front, bbc_queue, bbc_back.
//
// Usage:
//   text    : sink channel, one character byte per item with end_of_string
//             marking the last character of a string.
//   verdict : source channel, exactly one result item per input item.
//             finished echoes end_of_string; balanced is 1 while no bracket
//             mismatch has occurred, and on the last item also needs an empty
//             stack. State clears after each last item.
//   Path    : each character passes through the queue and then the output register
//             before its result item becomes valid.
//   Rate    : one item per cycle sustained while verdict is not held off; the stack
//             top sits in a register and the RAM read port keeps the next entry ready,
//             so pushes and pops may follow each other in every cycle.
//   Stall   : while verdict is held off, the queue fills, and text.ready drops
//             once it is full; nothing is lost or repeated.
//   Reset   : rst_n clears the stack count, failure flag, queue and output
//             valid at once. Stack RAM contents need no clearing.
//   STACK_DEPTH sets the stack size; a push onto a full stack is ignored.
module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    bbc_in_if.sink    text,
    bbc_out_if.source verdict
);

    logic fq_valid;
    logic fq_ready;
    op_t  fq_op;
    logic qb_valid;
    logic qb_ready;
    op_t  qb_op;

    // Accept and classify characters
    bbc_front u_front (
        .text    (text),
        .q_valid (fq_valid),
        .q_op    (fq_op),
        .q_ready (fq_ready)
    );

    // Decouple front and back
    bbc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_op    (fq_op),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_op    (qb_op)
    );

    // Run the stack and form the verdict
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_op    (qb_op),
        .verdict (verdict)
    );

endmodule

// ----- rtl/core/bbc_ram.sv -----
// Bracket balance checker: generic single-write, single-read RAM.
// Registered read, read-before-write on the same address. No dependencies.
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry registered
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/bbc_front.sv -----
// Bracket balance checker: front end that accepts characters and classifies them.
// Depends on bbc_pkg and bbc_in_if.
module bbc_front
    import bbc_pkg::*;
(
    bbc_in_if.sink text,
    output logic   q_valid,
    output op_t    q_op,
    input  logic   q_ready
);

    kind_t open_kind;
    kind_t close_kind;

    // Decode opening brackets
    always_comb
    begin
        case (text.char_code)
            CHAR_ROUND_OPEN:  open_kind = KIND_ROUND;
            CHAR_SQUARE_OPEN: open_kind = KIND_SQUARE;
            CHAR_CURLY_OPEN:  open_kind = KIND_CURLY;
            default:          open_kind = KIND_NONE;
        endcase
    end

    // Decode closing brackets
    always_comb
    begin
        case (text.char_code)
            CHAR_ROUND_CLOSE:  close_kind = KIND_ROUND;
            CHAR_SQUARE_CLOSE: close_kind = KIND_SQUARE;
            CHAR_CURLY_CLOSE:  close_kind = KIND_CURLY;
            default:           close_kind = KIND_NONE;
        endcase
    end

    // Pack the operation and pass the handshake through to the queue
    always_comb
    begin
        q_op.last     = text.end_of_string;
        q_op.is_open  = (open_kind != KIND_NONE);
        q_op.is_close = (close_kind != KIND_NONE);
        q_op.kind     = (open_kind != KIND_NONE) ? open_kind : close_kind;
    end

    assign q_valid    = text.valid;
    assign text.ready = q_ready;

endmodule

// ----- rtl/core/bbc_queue.sv -----
// Bracket balance checker: short queue of classified operations.
// Decouples the front from the stack back end. Depends on bbc_pkg.
module bbc_queue
    import bbc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  op_t  wr_op,
    output logic rd_valid,
    input  logic rd_ready,
    output op_t  rd_op
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    op_t           entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          push;
    logic          pop;

    assign wr_ready = (cnt_reg != CW'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_op    = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

`ifndef SYNTH
    // Fill level stays within the queue
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(QUEUE_DEPTH))
        else $error("queue fill level beyond depth");
`endif

endmodule

// ----- rtl/core/bbc_back.sv -----
// Bracket balance checker: back end holding the bracket stack and the verdict.
// Top of stack in a register, lower entries in bbc_ram. Depends on bbc_pkg, bbc_out_if.
module bbc_back
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_ready,
    input  op_t        q_op,
    bbc_out_if.source  verdict
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_after;
    logic [CW-1:0] count_less1;
    logic [CW-1:0] count_less2;
    logic          failed_reg;
    logic          failed_next;
    kind_t         top_reg;
    kind_t         top_next;
    logic          byp_reg;
    kind_t         byp_data_reg;
    kind_t         ram_rd_data;
    kind_t         below;
    logic          out_valid_reg;
    logic          finished_reg;
    logic          balanced_reg;
    logic          take;
    logic          cnt_zero;
    logic          cnt_full;
    logic          do_push;
    logic          do_close;
    logic          mismatch;
    logic          do_pop;
    logic          fail_after;
    logic          bal_now;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // Take an item whenever the output register is free or being drained
    assign q_ready  = !out_valid_reg || verdict.ready;
    assign take     = q_valid && q_ready;

    assign cnt_zero = (count_reg == '0);
    assign cnt_full = (count_reg == CW'(STACK_DEPTH));

    // Entry just below the top, forwarding a write made in the previous cycle
    assign below    = byp_reg ? byp_data_reg : ram_rd_data;

    // Carry out push, pop or mismatch
    always_comb
    begin
        do_push     = take && !failed_reg && q_op.is_open && !cnt_full;
        do_close    = take && !failed_reg && q_op.is_close;
        mismatch    = do_close && (cnt_zero || (top_reg != q_op.kind));
        do_pop      = do_close && !mismatch;
        fail_after  = failed_reg || mismatch;
        count_after = count_reg + CW'(do_push) - CW'(do_pop);
        bal_now     = !fail_after && (!q_op.last || (count_after == '0));

        count_next  = count_reg;
        failed_next = failed_reg;
        if (take)
        begin
            count_next  = q_op.last ? '0 : count_after;
            failed_next = q_op.last ? 1'b0 : fail_after;
        end

        top_next = top_reg;
        if (do_push)
        begin
            top_next = q_op.kind;
        end
        else if (do_pop)
        begin
            top_next = below;
        end
    end

    // Spill the old top on push; keep reading the entry below the next top
    assign count_less1 = count_reg - CW'(1);
    assign count_less2 = count_next - CW'(2);
    assign wr_en       = do_push && !cnt_zero;
    assign wr_addr     = count_less1[AW-1:0];
    assign rd_addr     = count_less2[AW-1:0];

    bbc_ram #(
        .WIDTH ($bits(kind_t)),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            failed_reg    <= 1'b0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            failed_reg <= failed_next;
            byp_reg    <= wr_en && (wr_addr == rd_addr);
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (verdict.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: top of stack, forwarded entry, result
    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        byp_data_reg <= top_reg;
        if (take)
        begin
            finished_reg <= q_op.last;
            balanced_reg <= bal_now;
        end
    end

    assign verdict.valid    = out_valid_reg;
    assign verdict.finished = finished_reg;
    assign verdict.balanced = balanced_reg;

`ifndef SYNTH
    // Stack depth is never exceeded
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // End of string clears the stack and the failure flag
    assert property (@(posedge clk) disable iff (!rst_n)
        take && q_op.last |=> (count_reg == '0) && !failed_reg)
        else $error("state not cleared after end of string");

    // A forwarded entry always comes from a spill in the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n) byp_reg |-> $past(wr_en))
        else $error("forwarding without a preceding write");
`endif

endmodule

// ----- tb/bracket_balance_checker_tb.sv -----
// Testbench for bracket_balance_checker: drives strings of character items and
// checks every verdict against a bracket stack predictor held in a scoreboard.
// Depends on bbc_pkg, bbc_in_if, bbc_out_if and the bracket_balance_checker RTL.
`timescale 1ns / 1ps

module bracket_balance_checker_tb;
    import bbc_pkg::*;

    localparam int          STACK_DEPTH = 128;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic finished;
        logic balanced;
    } verdict_t;

    // Ways of spoiling an otherwise well-formed string
    typedef enum int unsigned {
        FLAW_SWAP_KIND,
        FLAW_DROP_CHAR,
        FLAW_DROP_CLOSE,
        FLAW_ADD_CLOSE
    } flaw_t;

    logic clk;
    logic rst_n;

    bbc_in_if  text_ch ();
    bbc_out_if verdict_ch ();

    bracket_balance_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_ch),
        .verdict (verdict_ch)
    );

    // Bracket classification
    function automatic kind_t opener_kind(logic [7:0] c);
        case (c)
            CHAR_ROUND_OPEN:  return KIND_ROUND;
            CHAR_SQUARE_OPEN: return KIND_SQUARE;
            CHAR_CURLY_OPEN:  return KIND_CURLY;
            default:          return KIND_NONE;
        endcase
    endfunction

    function automatic kind_t closer_kind(logic [7:0] c);
        case (c)
            CHAR_ROUND_CLOSE:  return KIND_ROUND;
            CHAR_SQUARE_CLOSE: return KIND_SQUARE;
            CHAR_CURLY_CLOSE:  return KIND_CURLY;
            default:           return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] open_char(kind_t k);
        case (k)
            KIND_ROUND:  return CHAR_ROUND_OPEN;
            KIND_SQUARE: return CHAR_SQUARE_OPEN;
            default:     return CHAR_CURLY_OPEN;
        endcase
    endfunction

    function automatic logic [7:0] close_char(kind_t k);
        case (k)
            KIND_ROUND:  return CHAR_ROUND_CLOSE;
            KIND_SQUARE: return CHAR_SQUARE_CLOSE;
            default:     return CHAR_CURLY_CLOSE;
        endcase
    endfunction

    function automatic kind_t random_kind();
        return kind_t'($urandom_range(0, 2));
    endfunction

    // Scoreboard: tracks the bracket stack and holds the verdicts still owed
    class verdict_scoreboard;
        kind_t       stack_mem [STACK_DEPTH];
        int unsigned depth_used;
        bit          fail_seen;
        verdict_t    awaited [$];
        int unsigned mismatches;

        function new();
            depth_used = 0;
            fail_seen  = 1'b0;
            mismatches = 0;
        endfunction

        function void note_char(logic [7:0] c, logic last);
            kind_t    ok;
            kind_t    ck;
            verdict_t v;
            ok = opener_kind(c);
            ck = closer_kind(c);
            // Push or pop only while the string is still clean
            if (!fail_seen) begin
                if (ok != KIND_NONE) begin
                    if (depth_used < STACK_DEPTH) begin
                        stack_mem[depth_used] = ok;
                        depth_used++;
                    end
                end else if (ck != KIND_NONE) begin
                    if (depth_used == 0)
                        fail_seen = 1'b1;
                    else if (stack_mem[depth_used - 1] != ck)
                        fail_seen = 1'b1;
                    else
                        depth_used--;
                end
            end
            v.finished = last;
            v.balanced = !fail_seen && (!last || depth_used == 0);
            awaited.push_back(v);
            // Clear for the next string
            if (last) begin
                depth_used = 0;
                fail_seen  = 1'b0;
            end
        endfunction

        function void check_verdict(logic fin, logic bal);
            verdict_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: verdict finished=%b balanced=%b with none owed",
                             fin, bal);
                return;
            end
            want = awaited.pop_front();
            if (fin !== want.finished || bal !== want.balanced) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: verdict finished=%b balanced=%b, expected %b %b",
                             fin, bal, want.finished, want.balanced);
            end
        endfunction

        function int unsigned owed();
            return awaited.size();
        endfunction
    endclass

    verdict_scoreboard sb = new();

    int unsigned sender_idle   = 0;
    int unsigned receiver_idle = 0;
    int unsigned items_sent    = 0;
    int unsigned cycle_count   = 0;
    logic [7:0]  text_buf [$];

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Give up on a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stall the verdict channel at random
    always @(negedge clk) begin
        verdict_ch.ready <= ($urandom_range(0, 99) >= receiver_idle);
    end

    // Check each accepted verdict item
    always @(posedge clk) begin
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
            sb.check_verdict(verdict_ch.finished, verdict_ch.balanced);
    end

    // Offer one character item; returns at the falling edge after acceptance
    task automatic send_char(logic [7:0] c, logic last);
        while ($urandom_range(0, 99) < sender_idle) begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid         <= 1'b1;
        text_ch.char_code     <= c;
        text_ch.end_of_string <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        sb.note_char(c, last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    // Any byte that is not one of the six brackets
    function automatic logic [7:0] filler_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (opener_kind(c) != KIND_NONE || closer_kind(c) != KIND_NONE);
        return c;
    endfunction

    // Properly nested brackets with filler in between, all closed at the end
    function automatic void build_well_formed(int unsigned len);
        kind_t       opened [$];
        kind_t       k;
        int unsigned r;
        text_buf.delete();
        for (int unsigned i = 0; i < len; i++) begin
            r = $urandom_range(0, 9);
            if (r < 4 && opened.size() < STACK_DEPTH) begin
                k = random_kind();
                opened.push_back(k);
                text_buf.push_back(open_char(k));
            end else if (r < 7 && opened.size() > 0) begin
                text_buf.push_back(close_char(opened.pop_back()));
            end else begin
                text_buf.push_back(filler_char());
            end
        end
        while (opened.size() > 0)
            text_buf.push_back(close_char(opened.pop_back()));
    endfunction

    // Spoil a well-formed string in one place
    function automatic void add_flaw();
        int unsigned close_at [$];
        int unsigned idx;
        kind_t       k;
        flaw_t       flaw;
        flaw = flaw_t'($urandom_range(0, 3));
        for (int unsigned i = 0; i < text_buf.size(); i++)
            if (closer_kind(text_buf[i]) != KIND_NONE)
                close_at.push_back(i);
        case (flaw)
            FLAW_SWAP_KIND: begin
                if (close_at.size() > 0) begin
                    idx = close_at[$urandom_range(0, close_at.size() - 1)];
                    k = closer_kind(text_buf[idx]);
                    text_buf[idx] = close_char(kind_t'((k + 1) % 3));
                end else begin
                    text_buf.push_front(close_char(random_kind()));
                end
            end
            FLAW_DROP_CHAR: begin
                if (text_buf.size() > 1)
                    text_buf.delete($urandom_range(0, text_buf.size() - 1));
            end
            FLAW_DROP_CLOSE: begin
                if (close_at.size() > 0 && text_buf.size() > 1)
                    text_buf.delete(close_at[close_at.size() - 1]);
            end
            default: begin
                text_buf.insert($urandom_range(0, text_buf.size()), close_char(random_kind()));
            end
        endcase
    endfunction

    // Raw bytes, half of them brackets
    function automatic void build_noise(int unsigned len);
        kind_t k;
        text_buf.delete();
        for (int unsigned i = 0; i < len; i++) begin
            k = random_kind();
            if ($urandom_range(0, 1))
                text_buf.push_back(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 1))
                text_buf.push_back(open_char(k));
            else
                text_buf.push_back(close_char(k));
        end
    endfunction

    // Overfill the stack; pushes past the top are dropped, so only the first
    // STACK_DEPTH openers can be matched
    function automatic void build_deep(bit matched);
        kind_t       opened [$];
        kind_t       k;
        int unsigned extra;
        text_buf.delete();
        extra = $urandom_range(1, 5);
        for (int unsigned i = 0; i < STACK_DEPTH + extra; i++) begin
            k = random_kind();
            opened.push_back(k);
            text_buf.push_back(open_char(k));
        end
        text_buf.push_back(filler_char());
        if (matched) begin
            for (int i = STACK_DEPTH; i > 0; i--)
                text_buf.push_back(close_char(opened[i - 1]));
        end else begin
            for (int i = 0; i < 4; i++)
                text_buf.push_back(close_char(opened[opened.size() - 1 - i]));
        end
    endfunction

    // One idling profile with a mix of random strings
    task automatic run_phase(int unsigned send_idle, int unsigned recv_idle,
                             int unsigned budget, int unsigned deep_kind);
        int unsigned start;
        int unsigned pick;
        sender_idle   = send_idle;
        receiver_idle = recv_idle;
        start         = items_sent;
        if (deep_kind != 0) begin
            build_deep(deep_kind == 1);
            send_buffer();
        end
        while (items_sent - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                build_well_formed($urandom_range(1, 30));
            end else if (pick < 88) begin
                build_well_formed($urandom_range(1, 30));
                add_flaw();
            end else begin
                build_noise($urandom_range(1, 12));
            end
            send_buffer();
        end
    endtask

    initial begin
        rst_n                    = 1'b0;
        text_ch.valid            = 1'b0;
        text_ch.char_code        = 8'h00;
        text_ch.end_of_string    = 1'b0;
        verdict_ch.ready         = 1'b0;
        receiver_idle            = 52;
        sender_idle              = 30;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed strings: simple and nested matches, wrong kind, close on
        // empty, open left at the end, byte extremes, sticky failure
        send_text("()");
        send_text("[{()}]");
        send_text("(]");
        send_text(")");
        send_text("{");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("](");
        send_text("[)]");

        // Random strings under three idling profiles
        run_phase(30, 52, 470, 1);
        run_phase(52, 30, 470, 2);
        run_phase(0, 0, 470, 1);
        text_ch.valid <= 1'b0;

        // Drain outstanding verdicts, then allow for the pipeline
        while (sb.owed() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bbc_pkg.sv
rtl/core/bbc_in_if.sv
rtl/core/bbc_out_if.sv
rtl/core/bbc_ram.sv
rtl/core/bbc_front.sv
rtl/core/bbc_queue.sv
rtl/core/bbc_back.sv
rtl/core/bracket_balance_checker.sv
tb/bracket_balance_checker_tb.sv
